@@ src/stereo_rms_gate_normalizer_assert.svh @@
// Assertion macros for the stereo RMS gate normalizer.
`ifndef STEREO_RMS_GATE_NORMALIZER_ASSERT_SVH
`define STEREO_RMS_GATE_NORMALIZER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SRGN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SRGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/srgn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srgn_pkg;

  localparam int MAX_FRAME = 4096;

  localparam int SAMPLE_W  = 25;
  localparam int SUM_W     = 61;
  localparam int ROOT_W    = 31;
  localparam int SQ_W      = 50;
  localparam int FL_W      = 13;
  localparam int GR_W      = 9;
  localparam int PROD_W    = SAMPLE_W + FL_W;
  localparam int THR_W     = GR_W + ROOT_W;
  localparam int Q_W       = 29;
  localparam int OUT_W     = 30;
  localparam int REM_W     = ROOT_W + 1;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = FL_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_RATIO   = 1'd1;

  localparam logic [FL_W-1:0] FRAME_LENGTH_RST = 13'd1024;
  localparam logic [GR_W-1:0] GATE_RATIO_RST   = 9'd205;
  localparam logic [Q_W-1:0]  OUT_LIMIT        = 29'h1000_0000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Take bits 30..7 of a raw word as a signed 24-bit sample.
  function automatic sample_t word_sample(input logic [31:0] word);
    return sample_t'($signed(word[30:7]));
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_mag(input sample_t s);
    return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
  endfunction

endpackage

`default_nettype wire

@@ src/stereo_rms_gate_normalizer.sv @@
// Stereo RMS noise gate and normalizer.
// Input stream: one word per stereo pair, in_tdata = {right_word, left_word}.
// Each pair is folded to a mono sample and written into a two-bank frame
// store; its square joins the running sum of the frame. Every word yields one
// result word: the previous frame's sample at the same position, scaled by
// frame_length / root of that frame's square sum, as signed Q14.16, zero
// when below the gate. out_tuser is 0 until a full frame has been seen;
// out_tlast marks the word that closes a frame. Configuration writes go
// through cfg_* and must come only while idle; the block does not enforce
// this. A gated, saturated or not-yet-valid word runs the multiply,
// accumulate and output states; a scaled word also runs the restoring
// divider, one quotient bit per cycle. A new word is accepted only in the
// idle state. After the last word of a frame the square root iterates in
// parallel and holds off the next input word until it lands.
// A stalled receiver keeps the result in the output register; one more word
// is accepted and worked on, then input stalls until the register frees.
// Reset (synchronous, active low) empties the pipeline, zeroes the position,
// bank, sum and root, and restores frame_length 1024 and gate_ratio 205.
// Store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_rms_gate_normalizer_assert.svh"

module stereo_rms_gate_normalizer
  import srgn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,   // left_word[31:0], right_word[63:32]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // gated_value[29:0], zero pad[31:30]
  output logic                      out_tuser,  // value_valid[0]
  output logic                      out_tlast
);

  localparam int PW = $clog2(MAX_FRAME);
  localparam int AW = PW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [FL_W-1:0]     frame_len_r;
  logic [GR_W-1:0]     gate_r;
  logic [2:0]          state_r;
  logic [PW-1:0]       pos_r;
  logic                bank_r;
  logic                prev_ready_r;
  logic [SUM_W-1:0]    sum_r;
  logic [ROOT_W-1:0]   root_r;

  logic [SUM_W-1:0]    sv_r;
  logic [SUM_W-1:0]    sr_r;
  logic [SUM_W-1:0]    sbit_r;
  logic                sq_busy;

  sample_t             s_r;
  logic                last_r;
  logic                valid_r;
  logic [FL_W-1:0]     n_r;
  logic [ROOT_W-1:0]   root_use_r;
  logic                sign_r;
  logic [PROD_W-1:0]   prod_r;
  logic [THR_W-1:0]    thr_r;
  logic [SQ_W-1:0]     sq_r;
  logic [REM_W-1:0]    rem_r;
  logic [Q_W-1:0]      qd_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_tvalid_r;
  logic [OUT_W-1:0]    out_value_r;
  logic                out_user_r;
  logic                out_last_r;

  sample_t             mem [2*MAX_FRAME];
  sample_t             rd_q;

  logic                in_acc;
  sample_t             s_in;
  logic [FL_W-1:0]     n;
  logic                last;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] mag_p;
  logic [SAMPLE_W-1:0] mag_s;
  logic [SUM_W-1:0]    sum_nxt;
  logic                gated;
  logic                over;
  logic [REM_W-1:0]    shifted;
  logic                ge;
  logic [SUM_W-1:0]    sr_plus;
  logic [SUM_W-1:0]    sr_nxt;
  logic [SUM_W-1:0]    sv_nxt;
  logic [Q_W-1:0]      mag_q;
  logic [OUT_W-1:0]    value;
  logic                out_load;

  assign sq_busy   = (sbit_r != '0);
  assign in_tready = (state_r == S_IDLE) && !sq_busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s_in = word_sample(in_tdata[31:0]) + word_sample(in_tdata[63:32]);
    if (frame_len_r == '0) begin
      n = FL_W'(1);
    end else if ({19'd0, frame_len_r} > 32'(MAX_FRAME)) begin
      n = FL_W'(MAX_FRAME);
    end else begin
      n = frame_len_r;
    end
    last    = (17'(pos_r) + 17'd1) >= 17'(n);
    wr_addr = {bank_r, pos_r};
    rd_addr = {~bank_r, pos_r};
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wr_addr] <= s_in;
      rd_q         <= mem[rd_addr];
    end
  end

  always_comb begin
    mag_p   = sample_mag(rd_q);
    mag_s   = sample_mag(s_r);
    sum_nxt = sum_r + SUM_W'(sq_r);
    gated   = (root_use_r == '0) || ({prod_r, 8'd0} < (PROD_W + 8)'(thr_r));
    over    = 32'(prod_r[PROD_W-1:Q_W-16]) >= 32'(root_use_r);
    shifted = {rem_r[REM_W-2:0], qd_r[Q_W-1]};
    ge      = shifted >= {1'b0, root_use_r};
    sr_plus = sr_r + sbit_r;
    if (sv_r >= sr_plus) begin
      sv_nxt = sv_r - sr_plus;
      sr_nxt = (sr_r >> 1) + sbit_r;
    end else begin
      sv_nxt = sv_r;
      sr_nxt = sr_r >> 1;
    end
    mag_q    = (qd_r > OUT_LIMIT) ? OUT_LIMIT : qd_r;
    value    = sign_r ? (~{1'b0, mag_q} + 1'b1) : {1'b0, mag_q};
    out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  end

  // Control path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= FRAME_LENGTH_RST;
      gate_r       <= GATE_RATIO_RST;
      state_r      <= S_IDLE;
      pos_r        <= '0;
      bank_r       <= 1'b0;
      prev_ready_r <= 1'b0;
      sum_r        <= '0;
      root_r       <= '0;
      sbit_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FRAME_LENGTH: frame_len_r <= cfg_data;
          REG_GATE_RATIO:   gate_r      <= cfg_data[GR_W-1:0];
          default: ;
        endcase
      end
      if (sq_busy) begin
        sbit_r <= sbit_r >> 2;
        if (sbit_r[0]) begin
          root_r <= sr_nxt[ROOT_W-1:0];
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MUL;
            if (last) begin
              pos_r        <= '0;
              bank_r       <= ~bank_r;
              prev_ready_r <= 1'b1;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (last_r) begin
            sum_r  <= '0;
            sbit_r <= SUM_W'(1) << (SUM_W - 1);
          end else begin
            sum_r <= sum_nxt;
          end
          if (!valid_r || gated || over) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r        <= s_in;
      last_r     <= last;
      valid_r    <= prev_ready_r;
      n_r        <= n;
      root_use_r <= root_r;
    end
    if (state_r == S_MUL) begin
      sign_r <= rd_q[SAMPLE_W-1];
      prod_r <= PROD_W'(mag_p) * PROD_W'(n_r);
      thr_r  <= THR_W'(gate_r) * THR_W'(root_use_r);
      sq_r   <= SQ_W'(mag_s) * SQ_W'(mag_s);
    end
    if (state_r == S_ACC) begin
      if (last_r) begin
        sv_r <= sum_nxt;
        sr_r <= '0;
      end
      cnt_r <= CNT_W'(Q_W - 1);
      rem_r <= REM_W'(prod_r[PROD_W-1:Q_W-16]);
      if (!valid_r || gated) begin
        qd_r <= '0;
      end else if (over) begin
        qd_r <= OUT_LIMIT;
      end else begin
        qd_r <= {prod_r[Q_W-17:0], 16'd0};
      end
    end else if (sq_busy) begin
      sv_r <= sv_nxt;
      sr_r <= sr_nxt;
    end
    if (state_r == S_DIV) begin
      rem_r <= ge ? (shifted - {1'b0, root_use_r}) : shifted;
      qd_r  <= {qd_r[Q_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (out_load) begin
      out_value_r <= value;
      out_user_r  <= valid_r;
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_value_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `SRGN_ASSERT_NEXT(a_frame_wrap, in_acc && last, (pos_r == '0) && prev_ready_r, "frame end did not wrap position")
  `SRGN_ASSERT_NEXT(a_ready_sticky, prev_ready_r, prev_ready_r, "previous frame flag dropped")
  `SRGN_ASSERT_NEXT(a_div_done, (state_r == S_DIV) && (cnt_r == '0), state_r == S_OUT, "divider overran its count")
  `SRGN_ASSERT_SAME(a_root_start, $rose(sq_busy), $past(state_r == S_ACC && last_r), "root started off a frame end")

endmodule

`default_nettype wire

@@ tb/rms_gate_checker.sv @@
`timescale 1ns / 1ps

module rms_gate_checker
  import srgn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [63:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  localparam int FRAME_MAX = 4096;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             valid;
    logic             last;
  } norm_word_t;

  norm_word_t                 norm_q[$];
  logic [FL_W-1:0]            len_reg;
  logic [GR_W-1:0]            gate_reg;
  logic signed [SAMPLE_W-1:0] bank_mem [0:2*FRAME_MAX-1];
  int unsigned                wpos;
  logic                       wbank;
  logic [63:0]                energy;
  logic [31:0]                frame_root;
  logic                       primed;
  int                         fails = 0;
  int                         seen = 0;

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    logic [65:0] p;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      p = 66'(c) * 66'(c);
      if (p <= {2'b00, v}) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] gain_of(input logic signed [SAMPLE_W-1:0] s,
                                               input int unsigned len);
    longint      sv;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    if (frame_root == 0) return '0;
    sv = longint'(s);
    mag = (sv < 0) ? -sv : sv;
    prod = mag * 64'(len);
    if ((prod << 8) < 64'(gate_reg) * 64'(frame_root)) return '0;
    q = (prod << 16) / 64'(frame_root);
    if (q > 64'd268435456) q = 64'd268435456;
    if (sv < 0) q = -q;
    return q[OUT_W-1:0];
  endfunction

  task automatic fold_pair(input logic [31:0] lw, input logic [31:0] rw);
    logic signed [SAMPLE_W-1:0] mono;
    int unsigned                len;
    int unsigned                at;
    longint                     sv;
    logic [63:0]                sq;
    norm_word_t                 w;
    mono = {lw[30], lw[30:7]} + {rw[30], rw[30:7]};
    len = 32'(len_reg);
    if (len < 1) len = 1;
    if (len > FRAME_MAX) len = FRAME_MAX;
    at = wpos;
    w.valid = primed;
    w.value = primed ? gain_of(bank_mem[{~wbank, at[11:0]}], len) : '0;
    bank_mem[{wbank, at[11:0]}] = mono;
    sv = longint'(mono);
    sq = (sv < 0) ? -sv : sv;
    sq = sq * sq;
    energy = (energy > ~64'd0 - sq) ? ~64'd0 : energy + sq;
    w.last = (at + 1 >= len);
    if (w.last) begin
      frame_root = floor_root(energy);
      energy = '0;
      wbank = ~wbank;
      primed = 1'b1;
      wpos = 0;
    end else begin
      wpos = at + 1;
    end
    norm_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s mismatch on result %0d: got 0x%h, want 0x%h",
             $time, what, seen, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    norm_word_t w;
    if (!rst_n) begin
      len_reg = FRAME_LENGTH_RST;
      gate_reg = GATE_RATIO_RST;
      wpos = 0;
      wbank = 1'b0;
      energy = '0;
      frame_root = '0;
      primed = 1'b0;
      norm_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_LENGTH: len_reg = cfg_data[FL_W-1:0];
          REG_GATE_RATIO:   gate_reg = cfg_data[GR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) fold_pair(in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) begin
        if (norm_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, '0);
        end else begin
          w = norm_q.pop_front();
          if (out_tdata !== {2'b00, w.value}) report_mismatch("gated_value", out_tdata,
                                                              {2'b00, w.value});
          if (out_tuser !== w.valid) report_mismatch("value_valid", {31'd0, out_tuser},
                                                     {31'd0, w.valid});
          if (out_tlast !== w.last) report_mismatch("frame_end", {31'd0, out_tlast},
                                                    {31'd0, w.last});
        end
        seen++;
      end
    end
    fail_count <= fails;
    pending <= norm_q.size();
    checked <= seen;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import srgn_pkg::*;

  localparam int FRAME_MAX   = 4096;
  localparam int WORD_TARGET = 1170;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [63:0]          in_tdata;   // left_word[31:0], right_word[63:32]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;  // gated_value[29:0], zero pad[31:30]
  logic                 out_tuser;  // value_valid[0]
  logic                 out_tlast;
  int                   fail_count;
  int                   pending;
  int                   checked;

  int idle_pct = 0;
  int stall_pct = 0;
  int cur_len = 1024;
  int pos = 0;
  int bank = 0;
  int fill [0:1];
  bit primed = 1'b0;
  int words_sent = 0;
  int frames_done = 0;
  int max_len = 0;

  stereo_rms_gate_normalizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rms_gate_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] make_word(input int style);
    logic [23:0] v;
    int          mag;
    case (style)
      1: begin
        mag = $urandom_range(0, 8388607) >> $urandom_range(0, 23);
        v = $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
      end
      2: v = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'd0;
      3: v = 24'($urandom_range(0, 7)) - 24'd4;
      default: return $urandom;
    endcase
    return {1'($urandom_range(0, 1)), v, 7'($urandom_range(0, 127))};
  endfunction

  function automatic int pick_gate();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 256;
    if (r == 2) return 511;
    return $urandom_range(0, 511);
  endfunction

  // keep reads of the previous bank inside what has been written there
  function automatic int pick_len();
    int r;
    int hi;
    r = $urandom_range(0, 99);
    hi = (r < 55) ? 16 : (r < 88) ? 64 : 300;
    if (primed && hi > fill[1 - bank]) hi = fill[1 - bank];
    return $urandom_range(1, hi);
  endfunction

  function automatic int len_code(input int eff);
    if (eff == 1 && $urandom_range(0, 1)) return 0;
    if (eff == FRAME_MAX && $urandom_range(0, 1)) return $urandom_range(FRAME_MAX + 1, 8191);
    return eff;
  endfunction

  task automatic send_pair(input logic [31:0] lw, input logic [31:0] rw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rw, lw};
    do @(posedge clk); while (!in_tready);
    if (fill[bank] < pos + 1) fill[bank] = pos + 1;
    words_sent++;
    if (pos + 1 >= cur_len) begin
      bank = 1 - bank;
      pos = 0;
      primed = 1'b1;
      frames_done++;
    end else begin
      pos++;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_regs(input bit set_len, input int code, input bit set_gate,
                              input int gate);
    if (set_len) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FRAME_LENGTH;
      cfg_data <= CFG_W'(code);
      @(posedge clk);
      cur_len = (code < 1) ? 1 : (code > FRAME_MAX) ? FRAME_MAX : code;
      if (cur_len > max_len) max_len = cur_len;
    end
    if (set_gate) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_GATE_RATIO;
      cfg_data <= CFG_W'($urandom_range(0, 15) * 512 + gate);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase;
    int style;
    int count;
    bit set_len;
    bit set_gate;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    fill[0] = 0;
    fill[1] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first frame: extremes, nothing valid yet, length clamped from above
    program_regs(1, 8191, 0, 0);
    send_pair(32'h3FFFFF80, 32'h3FFFFF80);
    send_pair(32'hFFFFFFFF, 32'h00000000);
    send_pair(32'h80000000, 32'h7FFFFFFF);
    send_pair(32'h40000000, 32'h40000000);
    settle();
    program_regs(1, FRAME_MAX, 0, 0);
    send_pair(32'hBFFFFFFF, 32'h00000000);
    settle();
    // lower below the position: frame closes on the next word
    program_regs(1, 0, 0, 0);
    send_pair(32'h12345678, 32'h55555555);
    settle();
    program_regs(1, 2, 0, 0);
    send_pair(make_word(1), make_word(1));
    send_pair(make_word(1), make_word(1));
    settle();
    // tiny frame gives root 1, then stale entries overflow the scale
    program_regs(0, 0, 1, 511);
    send_pair(32'h00000080, 32'h00000000);
    send_pair(32'h00000000, 32'h00000000);
    settle();
    program_regs(1, 6, 1, 128);
    repeat (6) send_pair(32'h8000007F, 32'h0000007F);
    settle();
    // the frame just sent was all zero: root is zero for these random words
    program_regs(0, 0, 1, 0);
    repeat (3) send_pair(make_word(0), make_word(0));

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      settle();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if ($urandom_range(0, 9) < 7) begin
        set_len = $urandom_range(0, 3) != 0;
        set_gate = $urandom_range(0, 1);
        program_regs(set_len, len_code(pick_len()), set_gate, pick_gate());
      end
      style = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) count = (cur_len - pos) + cur_len * $urandom_range(0, 2);
      else count = $urandom_range(1, 60);
      if (count > 400) count = 400;
      if (count > WORD_TARGET - words_sent) count = WORD_TARGET - words_sent;
      repeat (count) send_pair(make_word(style), make_word(style));
      phase++;
    end

    settle();
    $display("Covered %0d stereo words in %0d frames over %0d idle/stall phases;",
             words_sent, frames_done, phase);
    $display("%0d result words compared, frame lengths 1..%0d, gate ratios 0..511.",
             checked, max_len);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
